// File: rtl/slt_pkg.sv
package slt_pkg;

  localparam int MaxIdents  = 128;
  localparam int MaxNameLen = 32;
  localparam int IdxW       = $clog2(MaxIdents);
  localparam int CntW       = $clog2(MaxIdents + 1);
  localparam int PosW       = $clog2(MaxNameLen);
  localparam int LenW       = $clog2(MaxNameLen + 1);
  localparam int AddrW      = $clog2(MaxIdents * MaxNameLen);
  localparam int KwNum      = 15;
  localparam int KwMaxLen   = 8;
  localparam int KindW      = 5;
  localparam int AttrW      = 31;

  localparam logic [AttrW-1:0] NumMax = {AttrW{1'b1}};

  localparam logic [KindW-1:0] K_IDENT  = 5'd15;
  localparam logic [KindW-1:0] K_NUMBER = 5'd16;
  localparam logic [KindW-1:0] K_RELOP  = 5'd17;
  localparam logic [KindW-1:0] K_ADDOP  = 5'd18;
  localparam logic [KindW-1:0] K_MULOP  = 5'd19;
  localparam logic [KindW-1:0] K_ASSIGN = 5'd20;
  localparam logic [KindW-1:0] K_COLON  = 5'd21;
  localparam logic [KindW-1:0] K_SEMI   = 5'd22;
  localparam logic [KindW-1:0] K_COMMA  = 5'd23;
  localparam logic [KindW-1:0] K_PERIOD = 5'd24;
  localparam logic [KindW-1:0] K_LPAREN = 5'd25;
  localparam logic [KindW-1:0] K_RPAREN = 5'd26;
  localparam logic [KindW-1:0] K_STRING = 5'd27;
  localparam logic [KindW-1:0] K_END    = 5'd28;
  localparam logic [KindW-1:0] K_ERROR  = 5'd29;

  localparam logic [2:0] RelLe = 3'd0;
  localparam logic [2:0] RelNe = 3'd1;
  localparam logic [2:0] RelLt = 3'd2;
  localparam logic [2:0] RelGt = 3'd3;
  localparam logic [2:0] RelGe = 3'd4;
  localparam logic [2:0] RelEq = 3'd5;
  localparam logic [2:0] OpFirst  = 3'd0;
  localparam logic [2:0] OpSecond = 3'd1;
  localparam logic [2:0] ErrLong = 3'd1;
  localparam logic [2:0] ErrFull = 3'd2;

  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;

  localparam logic [0:KwNum-1][63:0] KwText = {
    {"program", 8'h00}, {"begin", 24'h0}, {"var", 40'h0}, {"integer", 8'h00},
    {"char", 32'h0}, {"end", 40'h0}, {"if", 48'h0}, {"while", 24'h0},
    {"write", 24'h0}, {"writeln", 8'h00}, {"read", 32'h0}, {"readln", 16'h0},
    {"else", 32'h0}, {"then", 32'h0}, {"do", 48'h0}
  };
  localparam logic [0:KwNum-1][3:0] KwLen = {
    4'd7, 4'd5, 4'd3, 4'd7, 4'd4, 4'd3, 4'd2, 4'd5,
    4'd5, 4'd7, 4'd4, 4'd6, 4'd4, 4'd4, 4'd2
  };

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_NUM   = 3'd2,
    M_LT    = 3'd3,
    M_GT    = 3'd4,
    M_COLON = 3'd5,
    M_STR   = 3'd6
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0] token_kind;
    logic [AttrW-1:0] attribute;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] pos;
    logic [7:0]      ch;
  } wr_t;

  typedef struct packed {
    logic            start;
    logic [LenW-1:0] len;
  } req_t;

  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [IdxW-1:0] index;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [KindW-1:0] kind;
  } kw_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [2:0]       attr;
  } st_t;

  function automatic kw_t kw_lookup(input logic [LenW-1:0] len,
                                    input logic [KwMaxLen-1:0][7:0] wbuf);
    kw_t r;
    logic eq;
    r = '0;
    for (int k = 0; k < KwNum; k++) begin
      eq = (len == LenW'(KwLen[k]));
      for (int i = 0; i < KwMaxLen; i++) begin
        if (i < int'(KwLen[k]) && wbuf[i] != KwText[k][63-8*i -: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq && !r.hit) begin
        r.hit  = 1'b1;
        r.kind = KindW'(k);
      end
    end
    return r;
  endfunction

  function automatic st_t start_tok(input logic [7:0] c);
    st_t r;
    r = '0;
    r.valid = 1'b1;
    unique case (c)
      ChEq:     begin r.kind = K_RELOP;  r.attr = RelEq;    end
      ChPlus:   begin r.kind = K_ADDOP;  r.attr = OpFirst;  end
      ChMinus:  begin r.kind = K_ADDOP;  r.attr = OpSecond; end
      ChStar:   begin r.kind = K_MULOP;  r.attr = OpFirst;  end
      ChSlash:  begin r.kind = K_MULOP;  r.attr = OpSecond; end
      ChLparen: r.kind = K_LPAREN;
      ChRparen: r.kind = K_RPAREN;
      ChComma:  r.kind = K_COMMA;
      ChSemi:   r.kind = K_SEMI;
      ChPeriod: r.kind = K_PERIOD;
      default:  r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/source_lexer_tokenizer.sv
// lexer for a small pascal subset, one source byte per item
// input channel: in_valid_i / in_stall_o carry in_i (char_code, end_of_input)
// output channel: out_valid_o / out_stall_i carry out_o (token_kind, attribute,
//   last_of_run); an item gives zero, one or two tokens, the final one flagged
// a byte that only extends a token is accepted in idle, then scanned in step;
//   one that gives or ends a token also passes emit, tail or both, search aside
// a word end runs the identifier table engine on its memories: it checks the
//   length of each stored name, compares bytes with one of equal length, copies
//   a new name in bytewise; keywords and over-long words need no search
// first token of an item enters the output register from emit or tail after
//   the scan, or from emit after a search, once the output register is free
// the block takes a new byte while the last token waits in the output register
// a stalled receiver holds the output register; a second token then waits
//   in the scanner, and no new byte is taken until it leaves
// reset returns the scanner to idle and empties the identifier table;
//   no clearing pass is needed
module source_lexer_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  slt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output slt_pkg::out_t out_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STEP   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_EMIT1  = 5'b01000,
    S_TAIL   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  slt_pkg::mode_e mode_q, mode_d;
  logic [slt_pkg::LenW-1:0] len_q, len_d;
  logic over_q, over_d;
  logic [slt_pkg::AttrW-1:0] num_q, num_d;
  logic [slt_pkg::KwMaxLen-1:0][7:0] kw_q, kw_d;
  logic [7:0] ch_q, ch_d;
  logic eof_q, eof_d, rep_q, rep_d;
  logic [slt_pkg::KindW-1:0] kind_q, kind_d;
  logic [slt_pkg::AttrW-1:0] attr_q, attr_d;

  logic out_valid_q;
  slt_pkg::out_t out_q, push_data;
  logic push, push_ok, accept;

  slt_pkg::wr_t  wr;
  slt_pkg::req_t req;
  slt_pkg::res_t res;
  slt_pkg::kw_t  kw;
  slt_pkg::st_t  st;
  logic is_let, is_dig;
  logic [3:0] digit;
  logic [slt_pkg::AttrW+3:0] num_x;

  slt_ident_table u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .req_i (req),
    .res_o (res)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign push_ok    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign is_let = (ch_q >= 8'h61 && ch_q <= 8'h7A) || (ch_q >= 8'h41 && ch_q <= 8'h5A);
  assign is_dig = (ch_q >= 8'h30 && ch_q <= 8'h39);
  assign digit  = 4'(ch_q - slt_pkg::ChZero);
  assign num_x  = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + (slt_pkg::AttrW+4)'(digit);
  assign kw     = slt_pkg::kw_lookup(len_q, kw_q);
  assign st     = slt_pkg::start_tok(ch_q);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    len_d   = len_q;
    over_d  = over_q;
    num_d   = num_q;
    kw_d    = kw_q;
    ch_d    = ch_q;
    eof_d   = eof_q;
    rep_d   = rep_q;
    kind_d  = kind_q;
    attr_d  = attr_q;
    wr      = '0;
    req     = '0;
    push    = 1'b0;
    push_data = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ch_d    = in_i.char_code;
          eof_d   = in_i.end_of_input;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        rep_d  = 1'b0;
        attr_d = '0;
        unique case (mode_q)
          slt_pkg::M_WORD: begin
            if (!eof_q && (is_let || is_dig)) begin
              if (len_q < slt_pkg::LenW'(slt_pkg::MaxNameLen)) begin
                wr.valid = 1'b1;
                wr.pos   = len_q[slt_pkg::PosW-1:0];
                wr.ch    = ch_q;
                if (len_q < slt_pkg::LenW'(slt_pkg::KwMaxLen)) begin
                  kw_d[len_q[$clog2(slt_pkg::KwMaxLen)-1:0]] = ch_q;
                end
                len_d = len_q + slt_pkg::LenW'(1);
              end else begin
                over_d = 1'b1;
              end
              state_d = S_IDLE;
            end else begin
              rep_d  = 1'b1;
              mode_d = slt_pkg::M_IDLE;
              if (over_q) begin
                kind_d  = slt_pkg::K_ERROR;
                attr_d  = slt_pkg::AttrW'(slt_pkg::ErrLong);
                state_d = S_EMIT1;
              end else if (kw.hit) begin
                kind_d  = kw.kind;
                state_d = S_EMIT1;
              end else begin
                req.start = 1'b1;
                req.len   = len_q;
                state_d   = S_SEARCH;
              end
            end
          end
          slt_pkg::M_NUM: begin
            if (!eof_q && is_dig) begin
              num_d   = (num_x > (slt_pkg::AttrW+4)'(slt_pkg::NumMax)) ? slt_pkg::NumMax
                        : num_x[slt_pkg::AttrW-1:0];
              state_d = S_IDLE;
            end else begin
              mode_d  = slt_pkg::M_IDLE;
              kind_d  = slt_pkg::K_NUMBER;
              attr_d  = num_q;
              rep_d   = 1'b1;
              state_d = S_EMIT1;
            end
          end
          slt_pkg::M_LT: begin
            mode_d  = slt_pkg::M_IDLE;
            kind_d  = slt_pkg::K_RELOP;
            state_d = S_EMIT1;
            if (!eof_q && ch_q == slt_pkg::ChEq) begin
              attr_d = slt_pkg::AttrW'(slt_pkg::RelLe);
            end else if (!eof_q && ch_q == slt_pkg::ChGt) begin
              attr_d = slt_pkg::AttrW'(slt_pkg::RelNe);
            end else begin
              attr_d = slt_pkg::AttrW'(slt_pkg::RelLt);
              rep_d  = 1'b1;
            end
          end
          slt_pkg::M_GT: begin
            mode_d  = slt_pkg::M_IDLE;
            kind_d  = slt_pkg::K_RELOP;
            state_d = S_EMIT1;
            if (!eof_q && ch_q == slt_pkg::ChEq) begin
              attr_d = slt_pkg::AttrW'(slt_pkg::RelGe);
            end else begin
              attr_d = slt_pkg::AttrW'(slt_pkg::RelGt);
              rep_d  = 1'b1;
            end
          end
          slt_pkg::M_COLON: begin
            mode_d  = slt_pkg::M_IDLE;
            state_d = S_EMIT1;
            if (!eof_q && ch_q == slt_pkg::ChEq) begin
              kind_d = slt_pkg::K_ASSIGN;
            end else begin
              kind_d = slt_pkg::K_COLON;
              rep_d  = 1'b1;
            end
          end
          slt_pkg::M_STR: begin
            if (eof_q) begin
              mode_d  = slt_pkg::M_IDLE;
              state_d = S_TAIL;
            end else if (ch_q == slt_pkg::ChQuote) begin
              mode_d  = slt_pkg::M_IDLE;
              kind_d  = slt_pkg::K_STRING;
              state_d = S_EMIT1;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: begin
            rep_d   = 1'b1;
            state_d = S_TAIL;
          end
        endcase
      end
      S_SEARCH: begin
        if (res.valid) begin
          if (res.ok) begin
            kind_d = slt_pkg::K_IDENT;
            attr_d = slt_pkg::AttrW'(res.index);
          end else begin
            kind_d = slt_pkg::K_ERROR;
            attr_d = slt_pkg::AttrW'(slt_pkg::ErrFull);
          end
          state_d = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (push_ok) begin
          push = 1'b1;
          push_data.token_kind  = kind_q;
          push_data.attribute   = attr_q;
          push_data.last_of_run = !(eof_q || (rep_q && st.valid));
          state_d = (eof_q || rep_q) ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (eof_q) begin
          if (push_ok) begin
            push = 1'b1;
            push_data.token_kind  = slt_pkg::K_END;
            push_data.last_of_run = 1'b1;
            mode_d  = slt_pkg::M_IDLE;
            state_d = S_IDLE;
          end
        end else if (!rep_q) begin
          state_d = S_IDLE;
        end else if (!st.valid || push_ok) begin
          mode_d = slt_pkg::M_IDLE;
          if (is_let) begin
            mode_d   = slt_pkg::M_WORD;
            len_d    = slt_pkg::LenW'(1);
            over_d   = 1'b0;
            wr.valid = 1'b1;
            wr.ch    = ch_q;
            kw_d[0]  = ch_q;
          end else if (is_dig) begin
            mode_d = slt_pkg::M_NUM;
            num_d  = slt_pkg::AttrW'(digit);
          end else if (ch_q == slt_pkg::ChLt) begin
            mode_d = slt_pkg::M_LT;
          end else if (ch_q == slt_pkg::ChGt) begin
            mode_d = slt_pkg::M_GT;
          end else if (ch_q == slt_pkg::ChColon) begin
            mode_d = slt_pkg::M_COLON;
          end else if (ch_q == slt_pkg::ChQuote) begin
            mode_d = slt_pkg::M_STR;
          end
          if (st.valid) begin
            push = 1'b1;
            push_data.token_kind  = st.kind;
            push_data.attribute   = slt_pkg::AttrW'(st.attr);
            push_data.last_of_run = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    kw_q   <= kw_d;
    kind_q <= kind_d;
    attr_q <= attr_d;
    if (push) begin
      out_q <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= slt_pkg::M_IDLE;
      len_q       <= '0;
      over_q      <= 1'b0;
      num_q       <= '0;
      eof_q       <= 1'b0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      len_q   <= len_d;
      over_q  <= over_d;
      num_q   <= num_d;
      eof_q   <= eof_d;
      rep_q   <= rep_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("scanner state not one-hot");
  a_res_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> state_q == S_SEARCH)
    else $error("table result outside search");
  a_accept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_STEP)
    else $error("accepted item not scanned");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= slt_pkg::LenW'(slt_pkg::MaxNameLen))
    else $error("word length past limit");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ok)
    else $error("output register overwritten");

endmodule

// File: rtl/slt_ident_table.sv
module slt_ident_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slt_pkg::wr_t  wr_i,
  input  slt_pkg::req_t req_i,
  output slt_pkg::res_t res_o
);

  typedef enum logic [7:0] {
    T_IDLE = 8'b00000001,
    T_LRD  = 8'b00000010,
    T_LCHK = 8'b00000100,
    T_CRD  = 8'b00001000,
    T_CCHK = 8'b00010000,
    T_NEW  = 8'b00100000,
    T_PRD  = 8'b01000000,
    T_PWR  = 8'b10000000
  } tstate_e;

  tstate_e state_q, state_d;
  logic [slt_pkg::CntW-1:0]  count_q, count_d;
  logic [slt_pkg::IdxW-1:0]  slot_q, slot_d;
  logic [slt_pkg::PosW-1:0]  pos_q, pos_d;
  logic [slt_pkg::LenW-1:0]  len_q, len_d;

  logic [7:0] word_mem [slt_pkg::MaxNameLen];
  logic [7:0] char_mem [slt_pkg::MaxIdents * slt_pkg::MaxNameLen];
  logic [slt_pkg::LenW-1:0] len_mem [slt_pkg::MaxIdents];

  logic [7:0] word_rd_q, char_rd_q;
  logic [slt_pkg::LenW-1:0] len_rd_q;
  logic [slt_pkg::AddrW-1:0] rd_addr, wr_addr;
  logic char_we, len_we;
  logic last_slot, last_pos;

  assign rd_addr = slt_pkg::AddrW'(slt_pkg::AddrW'(slot_q) * slt_pkg::AddrW'(slt_pkg::MaxNameLen)
                   + slt_pkg::AddrW'(pos_q));
  assign wr_addr = slt_pkg::AddrW'(slt_pkg::AddrW'(count_q[slt_pkg::IdxW-1:0])
                   * slt_pkg::AddrW'(slt_pkg::MaxNameLen) + slt_pkg::AddrW'(pos_q));
  assign last_slot = (slt_pkg::CntW'(slot_q) + slt_pkg::CntW'(1)) == count_q;
  assign last_pos  = (slt_pkg::LenW'(pos_q) + slt_pkg::LenW'(1)) == len_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      word_mem[wr_i.pos] <= wr_i.ch;
    end
    word_rd_q <= word_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      char_mem[wr_addr] <= word_rd_q;
    end
    char_rd_q <= char_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[count_q[slt_pkg::IdxW-1:0]] <= len_q;
    end
    len_rd_q <= len_mem[slot_q];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    slot_d  = slot_q;
    pos_d   = pos_q;
    len_d   = len_q;
    char_we = 1'b0;
    len_we  = 1'b0;
    res_o   = '0;
    unique case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          len_d  = req_i.len;
          slot_d = '0;
          pos_d  = '0;
          state_d = (count_q == '0) ? T_NEW : T_LRD;
        end
      end
      T_LRD: state_d = T_LCHK;
      T_LCHK: begin
        pos_d = '0;
        if (len_rd_q == len_q) begin
          state_d = T_CRD;
        end else if (last_slot) begin
          state_d = T_NEW;
        end else begin
          slot_d  = slot_q + slt_pkg::IdxW'(1);
          state_d = T_LRD;
        end
      end
      T_CRD: state_d = T_CCHK;
      T_CCHK: begin
        if (char_rd_q != word_rd_q) begin
          pos_d = '0;
          if (last_slot) begin
            state_d = T_NEW;
          end else begin
            slot_d  = slot_q + slt_pkg::IdxW'(1);
            state_d = T_LRD;
          end
        end else if (last_pos) begin
          res_o.valid = 1'b1;
          res_o.ok    = 1'b1;
          res_o.index = slot_q;
          state_d     = T_IDLE;
        end else begin
          pos_d   = pos_q + slt_pkg::PosW'(1);
          state_d = T_CRD;
        end
      end
      T_NEW: begin
        pos_d = '0;
        if (count_q == slt_pkg::CntW'(slt_pkg::MaxIdents)) begin
          res_o.valid = 1'b1;
          state_d     = T_IDLE;
        end else begin
          state_d = T_PRD;
        end
      end
      T_PRD: state_d = T_PWR;
      T_PWR: begin
        char_we = 1'b1;
        if (last_pos) begin
          len_we      = 1'b1;
          count_d     = count_q + slt_pkg::CntW'(1);
          res_o.valid = 1'b1;
          res_o.ok    = 1'b1;
          res_o.index = count_q[slt_pkg::IdxW-1:0];
          state_d     = T_IDLE;
        end else begin
          pos_d   = pos_q + slt_pkg::PosW'(1);
          state_d = T_PRD;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      count_q <= '0;
      slot_q  <= '0;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      slot_q  <= slot_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

endmodule
